>>> hw/rtl/htsed_pkg.sv
// Shared types, character codes and entity tables for the tag stripper and entity decoder.
package htsed_pkg;

  localparam int unsigned HELD_DEPTH = 5;
  localparam int unsigned ENT_NUM    = 7;
  localparam int unsigned ENT_MAXLEN = 6;
  localparam int unsigned RUN_MAX    = 7;
  localparam int unsigned DEC_MAX    = 6;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_AW       = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW       = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_LT  = 8'h3c;
  localparam logic [7:0] CH_GT  = 8'h3e;
  localparam logic [7:0] CH_AMP = 8'h26;

  localparam logic [8*ENT_MAXLEN-1:0] ENT_STR [ENT_NUM] = '{
    {"&amp;", 8'h00},
    {"&lt;", 16'h0000},
    {"&gt;", 16'h0000},
    "&quot;",
    "&#x27;",
    {"&#39;", 8'h00},
    "&nbsp;"
  };

  localparam logic [2:0] ENT_LEN [ENT_NUM] = '{
    3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5, 3'd6
  };

  localparam logic [7:0] ENT_VAL [ENT_NUM] = '{
    8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27, 8'h20
  };

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    done;
    logic                    marker;
  } run_t;

  function automatic logic [7:0] ent_char(input int unsigned e, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int unsigned i = 0; i < ENT_MAXLEN; i++) begin
      if (pos == 3'(i)) begin
        c = ENT_STR[e][8*(ENT_MAXLEN-1-i) +: 8];
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/htsed_front.sv
// Front end: tag stripping, entity prefix tracking and building of the output run.
module htsed_front
  import htsed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       run_push_o,
  output run_t       run_o
);

  logic                  inside_q, inside_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [ENT_NUM-1:0]    mask_q, mask_d;
  logic [7:0]            held_q [HELD_DEPTH];
  logic [7:0]            nh [HELD_DEPTH];
  logic [7:0]            de [DEC_MAX];
  logic [2:0]            de_cnt, nh_cnt, n1, tot, k;
  logic [ENT_NUM-1:0]    match;
  logic                  complete, prefix, dec, is_amp, marker;
  logic [7:0]            val;

  always_comb begin
    n1       = cnt_q + 3'd1;
    is_amp   = in_byte_i == CH_AMP;
    dec      = !inside_q && (in_byte_i != CH_LT);
    complete = 1'b0;
    prefix   = 1'b0;
    val      = 8'h00;
    for (int unsigned e = 0; e < ENT_NUM; e++) begin
      match[e] = mask_q[e] && (cnt_q < ENT_LEN[e]) && (ent_char(e, cnt_q) == in_byte_i);
      if (match[e] && ENT_LEN[e] == n1) begin
        complete = 1'b1;
        val      = val | ENT_VAL[e];
      end
      if (match[e] && ENT_LEN[e] > n1) begin
        prefix = 1'b1;
      end
    end

    for (int unsigned i = 0; i < HELD_DEPTH; i++) begin
      de[i] = held_q[i];
      nh[i] = held_q[i];
    end
    de[DEC_MAX-1] = 8'h00;
    de_cnt = 3'd0;
    nh_cnt = cnt_q;
    mask_d = mask_q;

    if (dec) begin
      if (cnt_q != 3'd0 && complete) begin
        de[0]  = val;
        de_cnt = 3'd1;
        nh_cnt = 3'd0;
      end else if (cnt_q != 3'd0 && prefix && cnt_q < 3'(HELD_DEPTH)) begin
        for (int unsigned i = 0; i < HELD_DEPTH; i++) begin
          if (cnt_q == 3'(i)) begin
            nh[i] = in_byte_i;
          end
        end
        nh_cnt = n1;
        mask_d = match;
      end else begin
        for (int unsigned i = 0; i < DEC_MAX; i++) begin
          if (cnt_q == 3'(i)) begin
            de[i] = in_byte_i;
          end
        end
        if (is_amp) begin
          de_cnt = cnt_q;
          nh[0]  = CH_AMP;
          nh_cnt = 3'd1;
          mask_d = '1;
        end else begin
          de_cnt = n1;
          nh_cnt = 3'd0;
        end
      end
    end

    tot    = stream_end_i ? de_cnt + nh_cnt : de_cnt;
    marker = stream_end_i && (tot == 3'd0);

    for (int unsigned i = 0; i < RUN_MAX; i++) begin
      k = 3'(i) - de_cnt;
      run_o.bytes[i] = 8'h00;
      if (i < DEC_MAX && 3'(i) < de_cnt) begin
        run_o.bytes[i] = de[i];
      end else begin
        for (int unsigned j = 0; j < HELD_DEPTH; j++) begin
          if (k == 3'(j)) begin
            run_o.bytes[i] = nh[j];
          end
        end
      end
    end
    run_o.cnt    = marker ? 3'd1 : tot;
    run_o.done   = stream_end_i;
    run_o.marker = marker;
    run_push_o   = accept_i && ((tot != 3'd0) || stream_end_i);

    if (stream_end_i) begin
      inside_d = 1'b0;
      cnt_d    = 3'd0;
    end else begin
      inside_d = inside_q ? (in_byte_i != CH_GT) : (in_byte_i == CH_LT);
      cnt_d    = nh_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      cnt_q    <= 3'd0;
      mask_q   <= '0;
    end else if (accept_i) begin
      inside_q <= inside_d;
      cnt_q    <= cnt_d;
      mask_q   <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && dec) begin
      for (int unsigned i = 0; i < HELD_DEPTH; i++) begin
        held_q[i] <= nh[i];
      end
    end
  end

endmodule

>>> hw/rtl/htsed_queue.sv
// Short run queue between the front end and the back end.
module htsed_queue
  import htsed_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  run_t wr_data_i,
  input  logic rd_i,
  output run_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  run_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = count_q == Q_CW'(Q_DEPTH);
  assign empty_o   = count_q == '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + Q_CW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> hw/rtl/htsed_back.sv
// Back end: serializes the head run of the queue into single result bytes.
module htsed_back
  import htsed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       run_i,
  input  logic       run_empty_i,
  output logic       run_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       stream_done_o,
  output logic       run_last_o
);

  logic [2:0] idx_q, idx_d;
  logic       last, xfer;

  assign empty_o       = run_empty_i;
  assign last          = idx_q == (run_i.cnt - 3'd1);
  assign xfer          = pop_i && !run_empty_i;
  assign run_pop_o     = xfer && last;
  assign out_byte_o    = run_i.marker ? 8'h00 : run_i.bytes[idx_q];
  assign byte_valid_o  = !run_i.marker;
  assign stream_done_o = run_i.done && last;
  assign run_last_o    = last;
  assign idx_d         = last ? 3'd0 : idx_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (xfer) begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> hw/rtl/html_tag_strip_entity_decode_top.sv
// Top level of the HTML tag stripper and entity decoder.
//
// The input side is a queue write port: a byte and its end-of-stream flag
// transfer on a rising edge with push high and full low. The result side is a
// queue read port: while empty is low the oldest result is on the result
// ports, and it transfers on a rising edge with pop high.
// Bytes from a '<' through the next '>' are dropped, and the seven supported
// entities are replaced by one byte each. Bytes that may start an entity are
// held back and produce results only once the match resolves or the stream
// ends. The end of a stream flushes held bytes and yields a bare marker if
// nothing else is produced.
// An accepted byte's results enter the run queue as one run. The front end
// takes one byte per cycle while full is low; the back end delivers one
// result per cycle while pop is high, and the two-entry run queue between
// them sets how far the front end can run ahead.
// Reset clears the tag and match state and empties the queue. When the
// receiver stalls, the queue fills and full goes high until results drain.
module html_tag_strip_entity_decode_top
  import htsed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       stream_done_o,
  output logic       run_last_o
);

  run_t wr_run, rd_run;
  logic wr_push, rd_pop, q_empty, accept;

  assign accept = push && !full;

  htsed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .run_push_o   (wr_push),
    .run_o        (wr_run)
  );

  htsed_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_push),
    .wr_data_i (wr_run),
    .rd_i      (rd_pop),
    .rd_data_o (rd_run),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  htsed_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_i         (rd_run),
    .run_empty_i   (q_empty),
    .run_pop_o     (rd_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .stream_done_o (stream_done_o),
    .run_last_o    (run_last_o)
  );

endmodule
